// ===== src/tcas_pkg.sv =====
// Shared types and constants of the triple conflict admission store.
package tcas_pkg;

  localparam int unsigned FIELD_BITS    = 4;
  localparam int unsigned SLOTS_DEFAULT = 512;
  localparam int unsigned SLOT_W        = 9;
  localparam int unsigned COUNT_W       = 10;
  localparam int unsigned TRIPLE_W      = 3 * FIELD_BITS;

  typedef enum logic {
    OP_CHECK   = 1'b0,
    OP_PRELOAD = 1'b1
  } op_e;

  typedef struct packed {
    logic                  op;
    logic [FIELD_BITS-1:0] subj;
    logic [FIELD_BITS-1:0] pred;
    logic [FIELD_BITS-1:0] obj;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic               conflict_found;
    logic [SLOT_W-1:0]  conflict_slot;
    logic               store_full;
    logic [COUNT_W-1:0] stored_count;
  } out_item_t;

  // Stored layout: subject in the low field, then predicate, then object.
  typedef struct packed {
    logic [FIELD_BITS-1:0] obj;
    logic [FIELD_BITS-1:0] pred;
    logic [FIELD_BITS-1:0] subj;
  } triple_t;

  typedef struct packed {
    op_e     op;
    triple_t key;
  } cmd_t;

endpackage

// ===== src/tcas_ram.sv =====
// Generic simple dual-port RAM with a registered read.
module tcas_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/tcas_front.sv =====
// Input side: takes items, decodes them into commands and queues them for the scan engine.
module tcas_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tcas_pkg::in_item_t in_item_i,
  output logic              full_o,
  output logic              cmd_valid_o,
  output tcas_pkg::cmd_t    cmd_o,
  input  logic              cmd_pop_i
);
  import tcas_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push_acc;
  cmd_t       new_cmd;

  assign full_o      = (cnt_q == 2'd2);
  assign push_acc    = push_i && !full_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = entry_q[rd_ptr_q];

  always_comb begin
    new_cmd.op       = op_e'(in_item_i.op);
    new_cmd.key.subj = in_item_i.subj;
    new_cmd.key.pred = in_item_i.pred;
    new_cmd.key.obj  = in_item_i.obj;
  end

  always_comb begin
    wr_ptr_d = push_acc ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = cmd_pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_acc} - {1'b0, cmd_pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_acc) begin
      entry_q[wr_ptr_q] <= new_cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== src/tcas_back.sv =====
// Scan engine: appends commands to the store unless full or in conflict; holds results.
module tcas_back #(
  parameter int unsigned SLOTS = tcas_pkg::SLOTS_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  tcas_pkg::cmd_t     cmd_i,
  output logic               cmd_pop_o,
  output logic               empty_o,
  output tcas_pkg::out_item_t out_item_o,
  input  logic               pop_i
);
  import tcas_pkg::*;

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  state_e    state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [CW-1:0] count_q, count_d;
  triple_t   key_q, key_d;
  logic      out_valid_q;
  out_item_t out_q;

  logic          we;
  logic [IW-1:0] waddr;
  triple_t       wdata;
  logic [IW-1:0] raddr;
  triple_t       rdata;
  logic          res_we;
  out_item_t     res_d;
  logic          out_free;
  logic          hit;
  logic [CW-1:0] idx_next;
  logic [CW-1:0] count_inc;

  tcas_ram #(
    .WIDTH(TRIPLE_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Only this engine fills the output register, so a free register at the
  // start of a command stays free until that command finishes.
  assign out_free  = !out_valid_q || pop_i;
  assign hit       = (rdata.subj == key_q.subj) && (rdata.pred == key_q.pred) &&
                     (rdata.obj != key_q.obj);
  assign idx_next  = CW'(idx_q) + CW'(1);
  assign count_inc = count_q + CW'(1);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    count_d   = count_q;
    key_d     = key_q;
    cmd_pop_o = 1'b0;
    we        = 1'b0;
    waddr     = count_q[IW-1:0];
    wdata     = key_q;
    raddr     = idx_q + IW'(1);
    res_we    = 1'b0;
    res_d     = '0;
    unique case (state_q)
      ST_IDLE: begin
        raddr = '0;
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          key_d     = cmd_i.key;
          if (count_q == CW'(SLOTS)) begin
            res_we             = 1'b1;
            res_d.store_full   = 1'b1;
            res_d.stored_count = COUNT_W'(count_q);
          end else if (cmd_i.op == OP_PRELOAD || count_q == '0) begin
            we                 = 1'b1;
            wdata              = cmd_i.key;
            count_d            = count_inc;
            res_we             = 1'b1;
            res_d.accepted     = 1'b1;
            res_d.stored_count = COUNT_W'(count_inc);
          end else begin
            idx_d   = '0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // Read data here belongs to slot idx_q; the next slot is already requested.
        if (hit) begin
          res_we               = 1'b1;
          res_d.conflict_found = 1'b1;
          res_d.conflict_slot  = SLOT_W'(idx_q);
          res_d.stored_count   = COUNT_W'(count_q);
          state_d              = ST_IDLE;
        end else if (idx_next == count_q) begin
          we                 = 1'b1;
          count_d            = count_inc;
          res_we             = 1'b1;
          res_d.accepted     = 1'b1;
          res_d.stored_count = COUNT_W'(count_inc);
          state_d            = ST_IDLE;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    idx_q <= idx_d;
    if (res_we) begin
      out_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (res_we) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(SLOTS))
    else $error("fill count beyond store depth");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (CW'(idx_q) < count_q))
    else $error("scan index beyond occupied slots");

  a_result_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_we |-> (!out_valid_q || pop_i))
    else $error("result overwrites a waiting item");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> cmd_valid_i)
    else $error("command taken from an empty queue");

  a_append_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_we && res_d.accepted) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("accepted item did not advance the fill count");

endmodule

// ===== src/triple_conflict_admission_store.sv =====
// Top level of the triple conflict admission store.
// Items enter through a two-entry command queue and results leave through a
// one-entry output register, so the input side keeps taking items while a
// result waits. A checked insert reads the stored triples one per cycle from
// the store memory, from slot 0 up to the first conflicting slot or to the
// fill count. A preload, a checked insert into an empty store and any item
// that meets a full store need no scan: the engine writes their result into
// the output register as it takes the item.
// The store needs no clearing after reset; only slots below the fill count
// are ever compared.
module triple_conflict_admission_store #(
  parameter int unsigned SLOTS = tcas_pkg::SLOTS_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tcas_pkg::in_item_t  in_item_i,
  output logic                full_o,
  output logic                empty_o,
  output tcas_pkg::out_item_t out_item_o,
  input  logic                pop_i
);
  import tcas_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  tcas_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .in_item_i  (in_item_i),
    .full_o     (full_o),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  tcas_back #(
    .SLOTS(SLOTS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .empty_o    (empty_o),
    .out_item_o (out_item_o),
    .pop_i      (pop_i)
  );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the triple conflict admission store.
module tb;
  import tcas_pkg::*;

  localparam int unsigned SLOTS = SLOTS_DEFAULT;
  // This subject/predicate pair is kept out of the store until the last test.
  // Once it is stored, no earlier slot holds its pair, so the slot of a conflict is known.
  localparam logic [FIELD_BITS-1:0] HELD_SUBJ = 4'd10;
  localparam logic [FIELD_BITS-1:0] HELD_PRED = 4'd5;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      push_i    = 1'b0;
  in_item_t  in_item_i = '0;
  logic      full_o;
  logic      empty_o;
  out_item_t out_item_o;
  logic      pop_i     = 1'b0;

  triple_t     shadow_slots [SLOTS];
  int unsigned shadow_fill = 0;
  out_item_t   pending_results [$];
  int unsigned error_count = 0;
  bit          steady = 1'b0;

  triple_conflict_admission_store #(.SLOTS(SLOTS)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .in_item_i  (in_item_i),
    .full_o     (full_o),
    .empty_o    (empty_o),
    .out_item_o (out_item_o),
    .pop_i      (pop_i)
  );

  always #5 clk_i = ~clk_i;

  // Predicts the result of one item and updates the shadow store.
  function automatic out_item_t admit_triple(input in_item_t it);
    out_item_t res;
    triple_t   key;
    res      = '0;
    key.subj = it.subj;
    key.pred = it.pred;
    key.obj  = it.obj;
    if (shadow_fill >= SLOTS) begin
      res.store_full = 1'b1;
    end else begin
      if (op_e'(it.op) == OP_CHECK) begin
        for (int unsigned i = 0; i < shadow_fill; i++) begin
          if (!res.conflict_found && shadow_slots[i].subj == key.subj &&
              shadow_slots[i].pred == key.pred && shadow_slots[i].obj != key.obj) begin
            res.conflict_found = 1'b1;
            res.conflict_slot  = SLOT_W'(i);
          end
        end
      end
      if (!res.conflict_found) begin
        shadow_slots[shadow_fill] = key;
        shadow_fill++;
        res.accepted = 1'b1;
      end
    end
    res.stored_count = COUNT_W'(shadow_fill);
    return res;
  endfunction

  task automatic note_error(input string msg);
    if (error_count < 10) $display("%s", msg);
    error_count++;
  endtask

  // Expects to be called right after a rising edge; leaves push high.
  task automatic send_item(input op_e op, input logic [FIELD_BITS-1:0] subj,
                           input logic [FIELD_BITS-1:0] pred,
                           input logic [FIELD_BITS-1:0] obj);
    in_item_t it;
    it.op   = op;
    it.subj = subj;
    it.pred = pred;
    it.obj  = obj;
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < 18) begin
      push_i <= 1'b0;
      @(negedge clk_i);
    end
    push_i    <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    pending_results.insert(pending_results.size(), admit_triple(it));
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    push_i <= 1'b0;
  endtask

  always @(negedge clk_i) pop_i <= steady || ($urandom_range(99) >= 18);

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && pop_i && !empty_o) begin
      if (pending_results.size() == 0) begin
        note_error("result arrived with no item waiting for it");
      end else begin
        want = pending_results.pop_front();
        if (out_item_o.accepted !== want.accepted ||
            out_item_o.conflict_found !== want.conflict_found ||
            out_item_o.conflict_slot !== want.conflict_slot ||
            out_item_o.store_full !== want.store_full ||
            out_item_o.stored_count !== want.stored_count) begin
          note_error($sformatf({"mismatch: expected acc=%0d cf=%0d slot=%0d full=%0d ",
                                "cnt=%0d, got acc=%0d cf=%0d slot=%0d full=%0d cnt=%0d"},
                               want.accepted, want.conflict_found, want.conflict_slot,
                               want.store_full, want.stored_count,
                               out_item_o.accepted, out_item_o.conflict_found,
                               out_item_o.conflict_slot, out_item_o.store_full,
                               out_item_o.stored_count));
        end
      end
    end
  end

  // Conflicts against slot zero, duplicates, preloads that bypass the check,
  // and subject/predicate swaps that must not match.
  task automatic test_conflict_rules();
    send_item(OP_CHECK,   4'd0,  4'd0,  4'd0);
    send_item(OP_CHECK,   4'd0,  4'd0,  4'd15);
    send_item(OP_CHECK,   4'd0,  4'd0,  4'd0);
    send_item(OP_PRELOAD, 4'd0,  4'd0,  4'd15);
    send_item(OP_CHECK,   4'd0,  4'd0,  4'd5);
    send_item(OP_CHECK,   4'd15, 4'd15, 4'd15);
    send_item(OP_CHECK,   4'd15, 4'd15, 4'd0);
    send_item(OP_PRELOAD, 4'd15, 4'd15, 4'd0);
    send_item(OP_CHECK,   4'd15, 4'd0,  4'd7);
    send_item(OP_CHECK,   4'd0,  4'd15, 4'd7);
    send_item(OP_CHECK,   4'd3,  4'd5,  4'd1);
    send_item(OP_CHECK,   4'd5,  4'd3,  4'd2);
    send_item(OP_CHECK,   4'd3,  4'd5,  4'd2);
    send_item(OP_CHECK,   4'd15, 4'd0,  4'd7);
    stop_sending();
  endtask

  // Most items reuse a stored subject/predicate pair, so that duplicates and
  // conflicts at many slot depths are common.
  task automatic test_random_mix();
    op_e                   op;
    triple_t               pick;
    logic [FIELD_BITS-1:0] subj, pred, obj;
    for (int n = 0; n < 400; n++) begin
      steady = (n >= 150 && n < 250);
      op = ($urandom_range(3) == 0) ? OP_PRELOAD : OP_CHECK;
      if (shadow_fill != 0 && $urandom_range(9) < 7) begin
        pick = shadow_slots[$urandom_range(shadow_fill - 1)];
        subj = pick.subj;
        pred = pick.pred;
        obj  = $urandom_range(1) ? pick.obj : FIELD_BITS'($urandom_range(15));
      end else begin
        do begin
          subj = FIELD_BITS'($urandom_range(15));
          pred = FIELD_BITS'($urandom_range(15));
        end while (subj == HELD_SUBJ && pred == HELD_PRED);
        obj = FIELD_BITS'($urandom_range(15));
      end
      send_item(op, subj, pred, obj);
    end
    steady = 1'b0;
    stop_sending();
  endtask

  // Preloads fill the store, checked inserts scan it in full near the top,
  // and then both operations meet a full store.
  task automatic test_fill_to_capacity();
    logic [FIELD_BITS-1:0] subj, pred;
    while (shadow_fill < SLOTS - 3) begin
      do begin
        subj = FIELD_BITS'($urandom_range(15));
        pred = FIELD_BITS'($urandom_range(15));
      end while (subj == HELD_SUBJ && pred == HELD_PRED);
      send_item(OP_PRELOAD, subj, pred, FIELD_BITS'($urandom_range(15)));
    end
    send_item(OP_CHECK,   HELD_SUBJ, HELD_PRED, 4'd9);
    send_item(OP_CHECK,   HELD_SUBJ, HELD_PRED, 4'd4);
    send_item(OP_CHECK,   HELD_SUBJ, HELD_PRED, 4'd9);
    send_item(OP_PRELOAD, 4'd15, 4'd15, 4'd15);
    send_item(OP_CHECK,   4'd0,  4'd0,  4'd0);
    send_item(OP_PRELOAD, 4'd15, 4'd15, 4'd15);
    send_item(OP_CHECK,   HELD_SUBJ, HELD_PRED, 4'd4);
    for (int n = 0; n < 8; n++) begin
      send_item($urandom_range(1) ? OP_PRELOAD : OP_CHECK,
                FIELD_BITS'($urandom_range(15)),
                FIELD_BITS'($urandom_range(15)),
                FIELD_BITS'($urandom_range(15)));
    end
    stop_sending();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_conflict_rules();
    test_random_mix();
    test_fill_to_capacity();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SLOTS + 16) @(posedge clk_i);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
